### sv/gwd_pkg.sv
// shared types, constants and sine coefficients for the wave displacement unit
`default_nettype none
package gwd_pkg;

   localparam int NUM_WAVES_DEFAULT = 3;
   localparam int INDEX_W = 2;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_DISPLACE = 1'b1;

   // quarter-wave polynomial coefficients, Q30
   localparam logic [31:0] COEF_C1 = 32'd1686629713;
   localparam logic [31:0] COEF_C3 = 32'd693598668;
   localparam logic [31:0] COEF_C5 = 32'd85569307;
   localparam logic [31:0] COEF_C7 = 32'd5026995;
   localparam logic [31:0] COEF_C9 = 32'd172272;
   localparam logic [30:0] Q30_ONE = 31'h4000_0000;

   typedef struct packed {
      logic               opcode;
      logic [INDEX_W-1:0] wave_index;
      logic signed [31:0] dir_freq_x;
      logic signed [31:0] dir_freq_z;
      logic [31:0]        phase_offset;
      logic signed [31:0] crest_x;
      logic signed [31:0] crest_z;
      logic signed [31:0] wave_height;
      logic signed [31:0] point_x;
      logic signed [31:0] point_z;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
   } rsp_word_type;

   // one shared multiply: operands
   typedef struct packed {
      logic signed [32:0] a;
      logic signed [32:0] b;
   } mul_op_type;

endpackage
`default_nettype wire

### sv/gwd_mul.sv
// registered shared 33x33 signed multiplier
`default_nettype none
module gwd_mul
   import gwd_pkg::*;
(
   input  wire logic         clock,
   input  wire mul_op_type   op,
   output logic signed [65:0] prod_ff
);
   logic signed [65:0] prod_in;

   // product of the operands presented this cycle
   assign prod_in = op.a * op.b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule
`default_nettype wire

### sv/gerstner_wave_displacement_unit.sv
// Gerstner wave displacement unit: top level with wave table and sequencer
// A load word writes one wave entry. A displace word runs each wave in turn
// through a single shared 33x33 multiplier with a registered product: the
// phase, then the sine and the cosine polynomial, then the crest and height
// products and the step to the next wave; after the last wave the sums are
// rounded into the result register. The block takes no new word until the
// result register has been handed on.
`default_nettype none
module gerstner_wave_displacement_unit
   import gwd_pkg::*;
#(
   parameter int NUM_WAVES = NUM_WAVES_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_data
);
   localparam int WI_W = (NUM_WAVES > 1) ? $clog2(NUM_WAVES) : 1;

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_DOT_X = 5'd1;
   localparam logic [4:0] ST_DOT_Z = 5'd2;
   localparam logic [4:0] ST_DOT_W1 = 5'd3;
   localparam logic [4:0] ST_PHASE = 5'd4;
   localparam logic [4:0] ST_U2 = 5'd5;
   localparam logic [4:0] ST_H9 = 5'd6;
   localparam logic [4:0] ST_H7 = 5'd7;
   localparam logic [4:0] ST_H5 = 5'd8;
   localparam logic [4:0] ST_H3 = 5'd9;
   localparam logic [4:0] ST_HU = 5'd10;
   localparam logic [4:0] ST_HY = 5'd11;
   localparam logic [4:0] ST_ACC_CX = 5'd12;
   localparam logic [4:0] ST_ACC_CZ = 5'd13;
   localparam logic [4:0] ST_ACC_H = 5'd14;
   localparam logic [4:0] ST_ACC_W = 5'd15;
   localparam logic [4:0] ST_ROUND = 5'd16;
   localparam logic [4:0] ST_DONE = 5'd17;

   logic signed [31:0] fx_ff [NUM_WAVES];
   logic signed [31:0] fz_ff [NUM_WAVES];
   logic [31:0]        off_ff [NUM_WAVES];
   logic signed [31:0] cx_ff [NUM_WAVES];
   logic signed [31:0] cz_ff [NUM_WAVES];
   logic signed [31:0] hw_ff [NUM_WAVES];

   logic [4:0]         state_ff, state_in;
   logic [WI_W-1:0]    wave_ff, wave_in;
   logic               cos_ff, cos_in;
   logic signed [31:0] px_ff, pz_ff;
   logic signed [63:0] dot_ff, dot_in;
   logic [31:0]        phase_ff, phase_in;
   logic [30:0]        u_ff, u_in;
   logic [30:0]        u2_ff, u2_in;
   logic [31:0]        t_ff, t_in;
   logic               neg_ff, neg_in;
   logic signed [16:0] sin_ff, sin_in;
   logic signed [16:0] cos_val_ff, cos_val_in;
   logic signed [63:0] ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in;
   logic               rsp_valid_ff;
   rsp_word_type       rsp_ff;
   mul_op_type         mop;
   logic signed [65:0] prod;
   logic [65:0]        prod_u;
   logic [31:0]        pq;
   logic [31:0]        yq;
   logic [16:0]        yr;
   logic [16:0]        ylim;
   logic [31:0]        ph_src;
   logic               accept;

   gwd_mul u_mul (.clock(clock), .op(mop), .prod_ff(prod));

   assign prod_u = prod;
   assign pq = prod_u[61:30];
   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // round the Q30 quarter-wave value to Q15 and limit
   assign yq = pq + 32'd16384;
   assign yr = yq[31:15];
   assign ylim = (yr > 17'd32767) ? 17'd32767 : yr;

   // phase of the cosine pass, a quarter turn on from the sine
   assign ph_src = phase_ff + 32'h4000_0000;

   // operand selection for the shared multiplier
   always_comb begin
      mop.a = '0;
      mop.b = '0;
      unique case (state_ff)
         ST_DOT_X: begin
            mop.a = 33'(fx_ff[wave_ff]);
            mop.b = 33'(px_ff);
         end
         ST_DOT_Z: begin
            mop.a = 33'(fz_ff[wave_ff]);
            mop.b = 33'(pz_ff);
         end
         ST_U2: begin
            mop.a = {2'b00, u_ff};
            mop.b = {2'b00, u_ff};
         end
         ST_H9: begin
            mop.a = {2'b00, u2_in};
            mop.b = {1'b0, COEF_C9};
         end
         ST_H7, ST_H5, ST_H3: begin
            mop.a = {2'b00, u2_ff};
            mop.b = {1'b0, t_in};
         end
         ST_HU: begin
            mop.a = {2'b00, u_ff};
            mop.b = {1'b0, t_in};
         end
         ST_ACC_CX: begin
            mop.a = 33'(cx_ff[wave_ff]);
            mop.b = 33'(cos_val_ff);
         end
         ST_ACC_CZ: begin
            mop.a = 33'(cz_ff[wave_ff]);
            mop.b = 33'(cos_val_ff);
         end
         ST_ACC_H: begin
            mop.a = 33'(hw_ff[wave_ff]);
            mop.b = 33'(sin_ff);
         end
         default: begin
            mop.a = '0;
            mop.b = '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      wave_in = wave_ff;
      cos_in = cos_ff;
      dot_in = dot_ff;
      phase_in = phase_ff;
      u_in = u_ff;
      u2_in = u2_ff;
      t_in = t_ff;
      neg_in = neg_ff;
      sin_in = sin_ff;
      cos_val_in = cos_val_ff;
      ax_in = ax_ff;
      ay_in = ay_ff;
      az_in = az_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.opcode == OP_DISPLACE) begin
               state_in = ST_DOT_X;
               wave_in = '0;
               cos_in = 1'b0;
               ax_in = 64'(req_data.point_x) <<< 15;
               az_in = 64'(req_data.point_z) <<< 15;
               ay_in = '0;
            end
         end
         ST_DOT_X: state_in = ST_DOT_Z;
         ST_DOT_Z: begin
            dot_in = prod[63:0];
            state_in = ST_DOT_W1;
         end
         ST_DOT_W1: begin
            dot_in = dot_ff + prod[63:0];
            state_in = ST_PHASE;
         end
         ST_PHASE: begin
            phase_in = dot_ff[47:16] + off_ff[wave_ff];
            state_in = ST_U2;
            // first pass is the sine; select quarter fraction
            u_in = phase_in[30] ? (Q30_ONE - {1'b0, phase_in[29:0]})
                                : {1'b0, phase_in[29:0]};
            neg_in = phase_in[31];
         end
         ST_U2: state_in = ST_H9;
         ST_H9: begin
            u2_in = pq[30:0];
            state_in = ST_H7;
         end
         ST_H7: begin
            t_in = COEF_C7 - pq;
            state_in = ST_H5;
         end
         ST_H5: begin
            t_in = COEF_C5 - pq;
            state_in = ST_H3;
         end
         ST_H3: begin
            t_in = COEF_C3 - pq;
            state_in = ST_HU;
         end
         ST_HU: begin
            t_in = COEF_C1 - pq;
            state_in = ST_HY;
         end
         ST_HY: begin
            // product of u and t is now registered: finish this pass
            if (!cos_ff) begin
               sin_in = neg_ff ? -$signed({1'b0, ylim[15:0]})
                               : $signed({1'b0, ylim[15:0]});
               cos_in = 1'b1;
               u_in = ph_src[30] ? (Q30_ONE - {1'b0, ph_src[29:0]})
                                 : {1'b0, ph_src[29:0]};
               neg_in = ph_src[31];
               state_in = ST_U2;
            end else begin
               cos_val_in = neg_ff ? -$signed({1'b0, ylim[15:0]})
                                   : $signed({1'b0, ylim[15:0]});
               state_in = ST_ACC_CX;
            end
         end
         ST_ACC_CX: state_in = ST_ACC_CZ;
         ST_ACC_CZ: begin
            ax_in = ax_ff + prod[63:0];
            state_in = ST_ACC_H;
         end
         ST_ACC_H: begin
            az_in = az_ff + prod[63:0];
            state_in = ST_ACC_W;
         end
         ST_ACC_W: begin
            ay_in = ay_ff + prod[63:0];
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cos_in = 1'b0;
            if (32'(wave_ff) == 32'(NUM_WAVES - 1)) begin
               state_in = ST_DONE;
            end else begin
               wave_in = wave_ff + 1'b1;
               state_in = ST_DOT_X;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   function automatic logic [31:0] round_sat(input logic signed [63:0] acc);
      logic signed [63:0] s;
      logic signed [48:0] v;
      s = acc + 64'sd16384;
      v = s[63:15];
      if (v > 49'sh0_7FFF_FFFF) begin
         return 32'h7FFF_FFFF;
      end else if (v < -49'sh0_8000_0000) begin
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   // control and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         wave_ff <= '0;
         cos_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wave_ff <= wave_in;
         cos_ff <= cos_in;
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_DONE) begin
            rsp_valid_ff <= 1'b1;
         end
      end
      if (accept) begin
         px_ff <= req_data.point_x;
         pz_ff <= req_data.point_z;
      end
      dot_ff <= dot_in;
      phase_ff <= phase_in;
      u_ff <= u_in;
      u2_ff <= u2_in;
      t_ff <= t_in;
      neg_ff <= neg_in;
      sin_ff <= sin_in;
      cos_val_ff <= cos_val_in;
      ax_ff <= ax_in;
      ay_ff <= ay_in;
      az_ff <= az_in;
      if (state_ff == ST_DONE) begin
         rsp_ff.out_x <= round_sat(ax_ff);
         rsp_ff.out_y <= round_sat(ay_ff);
         rsp_ff.out_z <= round_sat(az_ff);
      end
   end

   // wave table, cleared at reset
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_WAVES; i++) begin
         if (reset) begin
            fx_ff[i] <= '0;
            fz_ff[i] <= '0;
            off_ff[i] <= '0;
            cx_ff[i] <= '0;
            cz_ff[i] <= '0;
            hw_ff[i] <= '0;
         end else if (accept && req_data.opcode == OP_LOAD
                      && 32'(req_data.wave_index) == i) begin
            fx_ff[i] <= req_data.dir_freq_x;
            fz_ff[i] <= req_data.dir_freq_z;
            off_ff[i] <= req_data.phase_offset;
            cx_ff[i] <= req_data.crest_x;
            cz_ff[i] <= req_data.crest_z;
            hw_ff[i] <= req_data.wave_height;
         end
      end
   end
endmodule
`default_nettype wire

### tb/gerstner_wave_displacement_unit_checker.sv
// checker: watches both channels, predicts displaced points and compares them
`default_nettype none
module gerstner_wave_displacement_unit_checker
   import gwd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_stall,
   input  wire req_word_type req_data,
   input  wire logic         rsp_valid,
   input  wire logic         rsp_stall,
   input  wire rsp_word_type rsp_data,
   output int                fail_count,
   output int                pending_count
);

   localparam int WAVES = NUM_WAVES_DEFAULT;

   logic [31:0] freq_x_mem [WAVES];
   logic [31:0] freq_z_mem [WAVES];
   logic [31:0] offset_mem [WAVES];
   logic [31:0] crest_x_mem [WAVES];
   logic [31:0] crest_z_mem [WAVES];
   logic [31:0] height_mem [WAVES];

   rsp_word_type expected_points [$];

   // quarter-wave sine, Q30 in, Q15 out
   function automatic longint unsigned quarter_wave(longint unsigned u);
      longint unsigned u2, t, y;
      u2 = (u * u) >> 30;
      t = COEF_C9;
      t = COEF_C7 - ((u2 * t) >> 30);
      t = COEF_C5 - ((u2 * t) >> 30);
      t = COEF_C3 - ((u2 * t) >> 30);
      t = COEF_C1 - ((u2 * t) >> 30);
      y = (u * t) >> 30;
      y = (y + 64'd16384) >> 15;
      if (y > 64'd32767) y = 64'd32767;
      return y;
   endfunction

   function automatic longint sine_of_phase(logic [31:0] phase);
      longint unsigned r;
      longint v;
      r = {34'd0, phase[29:0]};
      v = phase[30] ? longint'(quarter_wave(64'd1073741824 - r))
                    : longint'(quarter_wave(r));
      return phase[31] ? -v : v;
   endfunction

   function automatic logic [31:0] round_saturate(longint acc);
      longint v;
      v = (acc + 64'sd16384) >>> 15;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   function automatic rsp_word_type displace_point(req_word_type w);
      longint px, pz, ax, ay, az, dot, s, c;
      logic [31:0] phase;
      rsp_word_type r;
      px = longint'(w.point_x);
      pz = longint'(w.point_z);
      ax = px * 32768;
      az = pz * 32768;
      ay = 0;
      for (int i = 0; i < WAVES; i++) begin
         dot = longint'($signed(freq_x_mem[i])) * px
             + longint'($signed(freq_z_mem[i])) * pz;
         phase = dot[47:16] + offset_mem[i];
         s = sine_of_phase(phase);
         c = sine_of_phase(phase + 32'h4000_0000);
         ax += longint'($signed(crest_x_mem[i])) * c;
         az += longint'($signed(crest_z_mem[i])) * c;
         ay += longint'($signed(height_mem[i])) * s;
      end
      r.out_x = round_saturate(ax);
      r.out_y = round_saturate(ay);
      r.out_z = round_saturate(az);
      return r;
   endfunction

   // track accepted words on both channels
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WAVES; i++) begin
            freq_x_mem[i] = '0; freq_z_mem[i] = '0; offset_mem[i] = '0;
            crest_x_mem[i] = '0; crest_z_mem[i] = '0; height_mem[i] = '0;
         end
         expected_points.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result word %h", rsp_data);
            end else begin
               rsp_word_type e;
               e = expected_points.pop_front();
               if (e.out_x !== rsp_data.out_x || e.out_y !== rsp_data.out_y ||
                   e.out_z !== rsp_data.out_z) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected x %h y %h z %h, got x %h y %h z %h",
                              e.out_x, e.out_y, e.out_z,
                              rsp_data.out_x, rsp_data.out_y, rsp_data.out_z);
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_data.opcode == OP_DISPLACE) begin
               expected_points.push_back(displace_point(req_data));
            end else if (req_data.wave_index < WAVES) begin
               freq_x_mem[req_data.wave_index] = req_data.dir_freq_x;
               freq_z_mem[req_data.wave_index] = req_data.dir_freq_z;
               offset_mem[req_data.wave_index] = req_data.phase_offset;
               crest_x_mem[req_data.wave_index] = req_data.crest_x;
               crest_z_mem[req_data.wave_index] = req_data.crest_z;
               height_mem[req_data.wave_index] = req_data.wave_height;
            end
         end
      end
      pending_count = expected_points.size();
   end

endmodule
`default_nettype wire

### tb/gerstner_wave_displacement_unit_tb.sv
// testbench top: clock, reset, stimulus and verdict for the wave displacement unit
`default_nettype none
module gerstner_wave_displacement_unit_tb;
   import gwd_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;
   int           fail_count;
   int           pending_count;
   bit           stall_enable = 1'b0;

   gerstner_wave_displacement_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   gerstner_wave_displacement_unit_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver stall pattern: long free runs, then bursts of stalling
   int stall_phase = 0;
   always @(negedge clock) begin
      stall_phase <= (stall_phase + 1) % 97;
      if (!stall_enable || stall_phase < 40) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 2) != 0);
   end

   function automatic logic [31:0] edgy_word();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0;
         3: return 32'hffff_ffff;
         default: return $urandom();
      endcase
   endfunction

   // modest sizes keep sums in range; some large ones exercise saturation
   function automatic logic [31:0] shaped_word();
      case ($urandom_range(0, 3))
         0: return edgy_word();
         1: return $urandom();
         default: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
      endcase
   endfunction

   task automatic send_word(req_word_type w);
      req_data <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic idle_gap(int n);
      req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   function automatic req_word_type load_word(logic [1:0] idx);
      req_word_type w;
      w = '0;
      w.opcode = OP_LOAD;
      w.wave_index = idx;
      w.dir_freq_x = shaped_word(); w.dir_freq_z = shaped_word();
      w.phase_offset = $urandom();
      w.crest_x = shaped_word(); w.crest_z = shaped_word();
      w.wave_height = shaped_word();
      w.point_x = $urandom(); w.point_z = $urandom();
      return w;
   endfunction

   function automatic req_word_type displace_word();
      req_word_type w;
      w = '0;
      w.opcode = OP_DISPLACE;
      w.wave_index = 2'($urandom());
      w.dir_freq_x = $urandom(); w.dir_freq_z = $urandom();
      w.phase_offset = $urandom();
      w.crest_x = $urandom(); w.crest_z = $urandom(); w.wave_height = $urandom();
      w.point_x = shaped_word(); w.point_z = shaped_word();
      return w;
   endfunction

   initial begin
      req_word_type w;
      int burst;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: displace against the cleared table, extremes, unused entry
      w = displace_word(); w.point_x = 32'h7fff_ffff; w.point_z = 32'h8000_0000;
      send_word(w);
      for (int i = 0; i < 3; i++) begin
         w = load_word(i[1:0]);
         w.dir_freq_x = '0; w.dir_freq_z = '0;
         w.phase_offset = 32'h4000_0000 * i;
         w.crest_x = 32'h7fff_ffff; w.crest_z = 32'h8000_0000;
         w.wave_height = 32'h7fff_ffff;
         send_word(w);
      end
      w = displace_word(); w.point_x = 32'h7fff_ffff; w.point_z = 32'h8000_0000;
      send_word(w);
      w = load_word(2'd3); w.crest_x = 32'h1234_5678; send_word(w);
      w = displace_word(); w.point_x = '0; w.point_z = '0; send_word(w);
      for (int i = 0; i < 3; i++) begin
         w = load_word(i[1:0]);
         w.dir_freq_x = 32'h8000_0000; w.dir_freq_z = 32'h7fff_ffff;
         w.phase_offset = 32'hffff_ffff;
         w.crest_x = 32'h8000_0000; w.crest_z = 32'h7fff_ffff;
         w.wave_height = 32'h8000_0000;
         send_word(w);
      end
      w = displace_word(); w.point_x = 32'h8000_0000; w.point_z = 32'h8000_0000;
      send_word(w);
      w = displace_word(); w.point_x = 32'hffff_ffff; w.point_z = 32'h7fff_ffff;
      send_word(w);
      w = '1; w.opcode = OP_LOAD; w.wave_index = 2'd1; send_word(w);
      w = '1; send_word(w);

      // random: mostly displaces with occasional table reloads
      stall_enable = 1'b1;
      for (int n = 0; n < 1100; ) begin
         burst = $urandom_range(1, 12);
         for (int b = 0; b < burst; b++) begin
            if ($urandom_range(0, 5) == 0) send_word(load_word(2'($urandom_range(0, 3))));
            else send_word(displace_word());
            n++;
         end
         if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 30));
      end
      req_valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("gerstner_wave_displacement_unit_tb passed");
      end else begin
         $display("gerstner_wave_displacement_unit_tb failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20000000;
      $display("gerstner_wave_displacement_unit_tb failed");
      $finish;
   end

endmodule
`default_nettype wire

### gerstner_wave_displacement_unit.f
sv/gwd_pkg.sv
sv/gwd_mul.sv
sv/gerstner_wave_displacement_unit.sv
tb/gerstner_wave_displacement_unit_checker.sv
tb/gerstner_wave_displacement_unit_tb.sv
